@@ hw/rtl/parametric_line_pixel_stepper_assert.svh @@
// ----------------------------------------------------------------------------
// parametric line pixel stepper assertion macros
// shared concurrent assertion forms used by the rtl modules
// ----------------------------------------------------------------------------
`ifndef PARAMETRIC_LINE_PIXEL_STEPPER_ASSERT_SVH
`define PARAMETRIC_LINE_PIXEL_STEPPER_ASSERT_SVH

// same-cycle implication
`define PLPS_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PLPS_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/plps_pkg.sv @@
// ----------------------------------------------------------------------------
// plps_pkg
// types, codes and microcode rom of the parametric line pixel stepper
// ----------------------------------------------------------------------------
package plps_pkg;

  localparam int unsigned DIM_W     = 12;
  localparam int unsigned COLOR_W   = 24;
  localparam int unsigned CFG_IDX_W = 4;

  localparam logic [DIM_W-1:0] SURFACE_WIDTH_RESET  = DIM_W'(640);
  localparam logic [DIM_W-1:0] SURFACE_HEIGHT_RESET = DIM_W'(480);

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SURFACE_WIDTH  = CFG_IDX_W'(0),
    REG_SURFACE_HEIGHT = CFG_IDX_W'(1)
  } cfg_reg_t;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_SQUARE,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_LEN,
    OP_EMIT_FIRST,
    OP_MUL_T,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_EMIT_STEP
  } op_t;

  typedef enum logic [1:0] {
    J_NEXT,
    J_DISPATCH,
    J_LOOP,
    J_OUT
  } jmp_t;

  typedef logic [3:0] uaddr_t;

  localparam uaddr_t U_IDLE       = 4'd0;
  localparam uaddr_t U_SQUARE     = 4'd1;
  localparam uaddr_t U_SQRT_INIT  = 4'd2;
  localparam uaddr_t U_SQRT_STEP  = 4'd3;
  localparam uaddr_t U_LEN        = 4'd4;
  localparam uaddr_t U_EMIT_FIRST = 4'd5;
  localparam uaddr_t U_MUL_T      = 4'd6;
  localparam uaddr_t U_DIV_INIT   = 4'd7;
  localparam uaddr_t U_DIV_STEP   = 4'd8;
  localparam uaddr_t U_EMIT_STEP  = 4'd9;

  typedef struct packed {
    op_t    op;
    jmp_t   jmp;
    logic   cnt_load;
    uaddr_t target;
  } ctrl_word_t;

  typedef struct packed {
    logic in_valid;
    logic in_command;
    logic line_active;
    logic out_busy;
  } seq_status_t;

  typedef struct packed {
    op_t  op;
    logic idle;
    logic in_accept;
  } seq_ctrl_t;

  function automatic ctrl_word_t ucode_rom(input uaddr_t addr);
    ctrl_word_t w;
    w = '{op: OP_IDLE, jmp: J_DISPATCH, cnt_load: 1'b0, target: U_SQUARE};
    unique case (addr)
      U_IDLE:       w = '{OP_IDLE,       J_DISPATCH, 1'b0, U_SQUARE};
      U_SQUARE:     w = '{OP_SQUARE,     J_NEXT,     1'b0, U_IDLE};
      U_SQRT_INIT:  w = '{OP_SQRT_INIT,  J_NEXT,     1'b1, U_IDLE};
      U_SQRT_STEP:  w = '{OP_SQRT_STEP,  J_LOOP,     1'b0, U_SQRT_STEP};
      U_LEN:        w = '{OP_LEN,        J_NEXT,     1'b0, U_IDLE};
      U_EMIT_FIRST: w = '{OP_EMIT_FIRST, J_OUT,      1'b0, U_IDLE};
      U_MUL_T:      w = '{OP_MUL_T,      J_NEXT,     1'b0, U_IDLE};
      U_DIV_INIT:   w = '{OP_DIV_INIT,   J_NEXT,     1'b1, U_IDLE};
      U_DIV_STEP:   w = '{OP_DIV_STEP,   J_LOOP,     1'b0, U_DIV_STEP};
      U_EMIT_STEP:  w = '{OP_EMIT_STEP,  J_OUT,      1'b0, U_IDLE};
      default:      w = '{OP_IDLE,       J_DISPATCH, 1'b0, U_SQUARE};
    endcase
    return w;
  endfunction

endpackage

@@ hw/rtl/plps_seq.sv @@
// ----------------------------------------------------------------------------
// plps_seq
// microcode sequencer: step counter, loop counter and jump logic
// ----------------------------------------------------------------------------
`include "parametric_line_pixel_stepper_assert.svh"

module plps_seq #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  plps_pkg::seq_status_t status_i,
  output plps_pkg::seq_ctrl_t   ctrl_o
);
  import plps_pkg::*;

  localparam int unsigned CNT_W = $clog2(COORD_BITS + 2);
  localparam logic [CNT_W-1:0] LOOP_STEPS = CNT_W'(COORD_BITS + 1);

  uaddr_t           upc_r, upc_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  ctrl_word_t       cw;
  logic             accept;

  assign cw     = ucode_rom(upc_r);
  assign accept = status_i.in_valid && (cw.jmp == J_DISPATCH);

  always_comb begin
    upc_nxt = upc_r;
    unique case (cw.jmp)
      J_NEXT: upc_nxt = upc_r + uaddr_t'(1);
      J_DISPATCH: begin
        if (accept) begin
          if (status_i.in_command == CMD_START) begin
            upc_nxt = cw.target;
          end else if (status_i.line_active) begin
            upc_nxt = U_MUL_T;
          end
        end
      end
      J_LOOP: upc_nxt = (cnt_r != CNT_W'(1)) ? cw.target : upc_r + uaddr_t'(1);
      J_OUT: begin
        if (!status_i.out_busy) begin
          upc_nxt = cw.target;
        end
      end
      default: upc_nxt = U_IDLE;
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cw.cnt_load) begin
      cnt_nxt = LOOP_STEPS;
    end else if (cw.jmp == J_LOOP) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= U_IDLE;
      cnt_r <= '0;
    end else begin
      upc_r <= upc_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign ctrl_o.op        = cw.op;
  assign ctrl_o.idle      = (cw.jmp == J_DISPATCH);
  assign ctrl_o.in_accept = accept;

  `PLPS_ASSERT_NOW(a_loop_cnt, clk, rst_n, cw.jmp == J_LOOP, cnt_r != '0, "loop counter underflow")
  `PLPS_ASSERT_NOW(a_upc_range, clk, rst_n, 1'b1, upc_r <= U_EMIT_STEP, "step counter off program")
  `PLPS_ASSERT_NOW(a_accept_idle, clk, rst_n, accept, upc_r == U_IDLE, "input taken outside idle step")

endmodule

@@ hw/rtl/parametric_line_pixel_stepper.sv @@
// ----------------------------------------------------------------------------
// parametric_line_pixel_stepper
// parametric line rasterizer with microcoded sqrt and divide datapath
// ----------------------------------------------------------------------------
// input channel in_valid/in_stall: command 0 starts a line from start to end
// point with a color, command 1 asks for the next pixel of the active line.
// result channel out_valid/out_stall: one pixel word per start, one per step
// while a line is active; a step while idle is taken and gives nothing.
// config channel cfg_valid/cfg_ready (always ready): index 0 surface width,
// index 1 surface height, other indexes ignored.
// a start runs from accept to result through square, serial square root (one
// result bit a cycle), length and emit; a step runs through multiply, then x
// and y restoring dividers side by side (one quotient bit a cycle), and emit.
// one item is in work at a time; the next one can be taken once the result
// sits in the output register, even while the receiver stalls it.
// a stalled result holds and the sequencer waits at its emit step.
// reset (synchronous, rst_n low) clears the output, drops any line and
// loads surface size 640 by 480.
// ----------------------------------------------------------------------------
`include "parametric_line_pixel_stepper_assert.svh"

module parametric_line_pixel_stepper #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                               clk,
  input  logic                               rst_n,

  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_command,
  input  logic signed [COORD_BITS-1:0]       in_start_x,
  input  logic signed [COORD_BITS-1:0]       in_start_y,
  input  logic signed [COORD_BITS-1:0]       in_end_x,
  input  logic signed [COORD_BITS-1:0]       in_end_y,
  input  logic [plps_pkg::COLOR_W-1:0]       in_line_color,

  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [COORD_BITS-1:0]       out_pixel_x,
  output logic signed [COORD_BITS-1:0]       out_pixel_y,
  output logic [plps_pkg::COLOR_W-1:0]       out_pixel_color,
  output logic                               out_inside_res,
  output logic                               out_last,

  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [plps_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [plps_pkg::DIM_W-1:0]         cfg_wdata
);
  import plps_pkg::*;

  localparam int unsigned C     = COORD_BITS;
  localparam int unsigned DW    = C + 1;
  localparam int unsigned PW    = 2 * C + 2;
  localparam int unsigned XW    = C + 2;
  localparam int unsigned RW    = C + 2;
  localparam int unsigned SW    = C + 4;
  localparam int unsigned CMPW  = (XW - 1 > DIM_W) ? XW - 1 : DIM_W;
  localparam int unsigned LANES = 2;

  // lane 0 is x, lane 1 is y
  logic [DIM_W-1:0]          surf_w_r, surf_h_r;
  logic signed [C-1:0]       origin_r [LANES];
  logic signed [DW-1:0]      delta_r  [LANES];
  logic [PW-1:0]             prod_r   [LANES];
  logic [DW-1:0]             drem_r   [LANES];
  logic [DW-1:0]             dq_r     [LANES];
  logic [DW-1:0]             step_count_r, step_index_r;
  logic [COLOR_W-1:0]        held_color_r;
  logic                      line_active_r;
  logic [PW-1:0]             sq_r;
  logic [DW-1:0]             root_r;
  logic [RW-1:0]             srem_r;

  logic                      out_valid_r;
  logic signed [C-1:0]       out_pixel_x_r, out_pixel_y_r;
  logic [COLOR_W-1:0]        out_pixel_color_r;
  logic                      out_inside_res_r, out_last_r;

  seq_status_t               status;
  seq_ctrl_t                 ctrl;

  logic signed [C-1:0]       start_in [LANES];
  logic signed [C-1:0]       end_in   [LANES];
  logic [DW-1:0]             mag      [LANES];
  logic [DW-1:0]             mul_b    [LANES];
  logic [PW-1:0]             mul      [LANES];
  logic [DW:0]               dsh      [LANES];
  logic                      dge      [LANES];
  logic signed [XW-1:0]      qv       [LANES];
  logic signed [XW-1:0]      coord    [LANES];

  logic [SW-1:0]             srem_sh, trial, srem_diff;
  logic                      sge;
  logic                      out_busy, emit_first, emit_fire, emit_last, on_surface;
  logic                      step_accept, start_accept;

  assign out_busy     = out_valid_r && out_stall;
  assign emit_first   = (ctrl.op == OP_EMIT_FIRST);
  assign emit_fire    = (emit_first || ctrl.op == OP_EMIT_STEP) && !out_busy;
  assign emit_last    = emit_first ? (step_count_r == '0) : (step_index_r >= step_count_r);
  assign start_accept = ctrl.in_accept && (in_command == CMD_START);
  assign step_accept  = ctrl.in_accept && (in_command == CMD_STEP) && line_active_r;

  assign status.in_valid    = in_valid;
  assign status.in_command  = in_command;
  assign status.line_active = line_active_r;
  assign status.out_busy    = out_busy;

  plps_seq #(
    .COORD_BITS(COORD_BITS)
  ) u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .status_i(status),
    .ctrl_o  (ctrl)
  );

  assign in_stall  = !ctrl.idle;
  assign cfg_ready = 1'b1;

  always_comb begin
    start_in[0] = in_start_x;
    start_in[1] = in_start_y;
    end_in[0]   = in_end_x;
    end_in[1]   = in_end_y;
    for (int i = 0; i < LANES; i++) begin
      mag[i]   = delta_r[i][DW-1] ? DW'(-delta_r[i]) : DW'(delta_r[i]);
      mul_b[i] = (ctrl.op == OP_SQUARE) ? mag[i] : step_index_r;
      mul[i]   = PW'(mag[i]) * PW'(mul_b[i]);
      dsh[i]   = {drem_r[i], dq_r[i][DW-1]};
      dge[i]   = dsh[i] >= {1'b0, step_count_r};
      qv[i]    = delta_r[i][DW-1] ? -signed'(XW'(dq_r[i])) : signed'(XW'(dq_r[i]));
      coord[i] = emit_first ? XW'(origin_r[i]) : XW'(origin_r[i]) + qv[i];
    end
  end

  // one square root digit per step
  always_comb begin
    srem_sh   = {srem_r, sq_r[PW-1 -: 2]};
    trial     = SW'({root_r, 2'b01});
    sge       = srem_sh >= trial;
    srem_diff = sge ? srem_sh - trial : srem_sh;
  end

  assign on_surface = !coord[0][XW-1] && !coord[1][XW-1]
                   && (CMPW'(coord[0][XW-2:0]) < CMPW'(surf_w_r))
                   && (CMPW'(coord[1][XW-2:0]) < CMPW'(surf_h_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      surf_w_r <= SURFACE_WIDTH_RESET;
      surf_h_r <= SURFACE_HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SURFACE_WIDTH:  surf_w_r <= cfg_wdata;
        REG_SURFACE_HEIGHT: surf_h_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_active_r <= 1'b0;
    end else if (start_accept) begin
      line_active_r <= 1'b0;
    end else if (ctrl.op == OP_LEN) begin
      line_active_r <= (root_r != '0) || (srem_r != '0);
    end else if (emit_fire && !emit_first && emit_last) begin
      line_active_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start_accept) begin
      held_color_r <= in_line_color;
      step_index_r <= '0;
    end else if (step_accept) begin
      step_index_r <= step_index_r + DW'(1);
    end
    for (int i = 0; i < LANES; i++) begin
      if (start_accept) begin
        origin_r[i] <= start_in[i];
        delta_r[i]  <= DW'(end_in[i]) - DW'(start_in[i]);
      end
      if (ctrl.op == OP_SQUARE || ctrl.op == OP_MUL_T) begin
        prod_r[i] <= mul[i];
      end
      if (ctrl.op == OP_DIV_INIT) begin
        drem_r[i] <= prod_r[i][PW-1 -: DW];
        dq_r[i]   <= prod_r[i][DW-1:0];
      end else if (ctrl.op == OP_DIV_STEP) begin
        drem_r[i] <= dge[i] ? DW'(dsh[i] - {1'b0, step_count_r}) : DW'(dsh[i]);
        dq_r[i]   <= {dq_r[i][DW-2:0], dge[i]};
      end
    end
    case (ctrl.op)
      OP_SQRT_INIT: begin
        sq_r   <= prod_r[0] + prod_r[1];
        root_r <= '0;
        srem_r <= '0;
      end
      OP_SQRT_STEP: begin
        sq_r   <= {sq_r[PW-3:0], 2'b00};
        root_r <= {root_r[DW-2:0], sge};
        srem_r <= srem_diff[RW-1:0];
      end
      OP_LEN: step_count_r <= root_r + DW'(srem_r != '0);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_pixel_x_r     <= coord[0][C-1:0];
      out_pixel_y_r     <= coord[1][C-1:0];
      out_pixel_color_r <= held_color_r;
      out_inside_res_r  <= on_surface;
      out_last_r        <= emit_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_x     = out_pixel_x_r;
  assign out_pixel_y     = out_pixel_y_r;
  assign out_pixel_color = out_pixel_color_r;
  assign out_inside_res  = out_inside_res_r;
  assign out_last        = out_last_r;

  `PLPS_ASSERT_NOW(a_active_len, clk, rst_n, line_active_r, step_count_r != '0, "active line with zero length")
  `PLPS_ASSERT_NOW(a_index_bound, clk, rst_n, line_active_r, step_index_r <= step_count_r, "step index past length")
  `PLPS_ASSERT_NEXT(a_last_idle, clk, rst_n, emit_fire && emit_last, !line_active_r, "line still active after last pixel")
  `PLPS_ASSERT_NOW(a_div_rem, clk, rst_n, ctrl.op == OP_DIV_STEP, drem_r[0] < step_count_r && drem_r[1] < step_count_r, "divider remainder out of range")

endmodule
